// File: hdl/token_bucket_sequence_admission_defines.svh
// Assertion macros used by the top-level RTL file.
// Left empty when SYNTH is defined.
`ifndef TOKEN_BUCKET_SEQUENCE_ADMISSION_DEFINES_SVH
`define TOKEN_BUCKET_SEQUENCE_ADMISSION_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define TBSA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbsa: same-cycle check failed");
// next-cycle implication
`define TBSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tbsa: next-cycle check failed");
`else
`define TBSA_ASSERT_NOW(label, clk, rst, ante, cons)
`define TBSA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hdl/tbsa_pkg.sv
package tbsa_pkg;

   localparam int SEQ_W     = 32;
   localparam int TIME_W    = 64;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;
   localparam int LEVEL_W   = 26;
   localparam int CNT_W     = 32;
   localparam int PROD_W    = LEVEL_W + CSR_W;

   localparam logic [CSR_IDX_W-1:0] CSR_REFILL_PER_MS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_TOKENS  = 1'd1;

   localparam logic [CSR_W-1:0]   REFILL_RESET    = 16'd60;
   localparam logic [CSR_W-1:0]   BURST_RESET     = 16'd8;
   localparam logic [LEVEL_W-1:0] MILLI_PER_TOKEN = 26'd1000;
   // elapsed time beyond this saturates the refill
   localparam logic [LEVEL_W-1:0] ELAPSED_SAT     = 26'h3FF_FFFF;

   typedef enum logic [1:0] {
      VERDICT_ADMIT = 2'd0,
      VERDICT_RATE  = 2'd1,
      VERDICT_STALE = 2'd2
   } verdict_type;

   // word handed from the refill pipe to the admission stage
   typedef struct packed {
      logic [SEQ_W-1:0]   seq;
      logic               first;   // first word after reset: fill to capacity
      logic               refill;  // time did not run backward: add and clamp
      logic [LEVEL_W-1:0] add;     // milli-tokens to add, already <= capacity
   } refill_word_type;

   // bucket capacity in milli-tokens
   function automatic logic [LEVEL_W-1:0] burst_to_cap(input logic [CSR_W-1:0] burst);
      logic [LEVEL_W-1:0] cap;
      cap = LEVEL_W'(burst) * MILLI_PER_TOKEN;
      return cap;
   endfunction

endpackage

// File: hdl/tbsa_if.sv
interface tbsa_req_if;
   logic                       valid;
   logic                       ready;
   logic [tbsa_pkg::SEQ_W-1:0]  sequence_req;
   logic [tbsa_pkg::TIME_W-1:0] now_ms;

   modport source (output valid, output sequence_req, output now_ms, input ready);
   modport sink   (input valid, input sequence_req, input now_ms, output ready);
endinterface

interface tbsa_rsp_if;
   logic                       valid;
   logic                       ready;
   tbsa_pkg::verdict_type      verdict;
   logic [tbsa_pkg::CNT_W-1:0] admitted_total;
   logic [tbsa_pkg::CNT_W-1:0] rate_rejected_total;
   logic [tbsa_pkg::CNT_W-1:0] stale_rejected_total;

   modport source (output valid, output verdict, output admitted_total,
                   output rate_rejected_total, output stale_rejected_total, input ready);
   modport sink   (input valid, input verdict, input admitted_total,
                   input rate_rejected_total, input stale_rejected_total, output ready);
endinterface

// File: hdl/tbsa_refill.sv
module tbsa_refill (
   input  logic                             clock,
   input  logic                             reset,
   tbsa_req_if.sink                         req_bus,
   input  logic [tbsa_pkg::CSR_W-1:0]       refill_per_ms,
   input  logic [tbsa_pkg::LEVEL_W-1:0]     cap,
   output logic                             out_valid,
   input  logic                             out_ready,
   output tbsa_pkg::refill_word_type        out_word
);
   import tbsa_pkg::*;

   // s0: input register
   logic              s0_valid_ff;
   logic [SEQ_W-1:0]  s0_seq_ff;
   logic [TIME_W-1:0] s0_now_ff;
   // time tracking, updated as a word leaves s0
   logic              started_ff;
   logic [TIME_W-1:0] last_now_ff;
   // s1: elapsed time
   logic               s1_valid_ff;
   logic [SEQ_W-1:0]   s1_seq_ff;
   logic               s1_first_ff, s1_refill_ff, s1_sat_ff;
   logic [LEVEL_W-1:0] s1_elapsed_ff;
   // s2: product
   logic               s2_valid_ff;
   logic [SEQ_W-1:0]   s2_seq_ff;
   logic               s2_first_ff, s2_refill_ff, s2_sat_ff;
   logic [PROD_W-1:0]  s2_prod_ff;
   // s3: clamped add amount
   logic              s3_valid_ff;
   refill_word_type   s3_word_ff;

   logic s0_ready, s1_ready, s2_ready, s3_ready;
   logic [TIME_W-1:0]  diff_in;
   logic               backward_in, sat_in;
   logic [PROD_W-1:0]  prod_in;
   logic [LEVEL_W-1:0] add_in;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign s0_ready = !s0_valid_ff || s1_ready;
   assign req_bus.ready = s0_ready;

   always_comb begin
      diff_in     = s0_now_ff - last_now_ff;
      backward_in = started_ff && (s0_now_ff < last_now_ff);
      sat_in      = (diff_in > TIME_W'(ELAPSED_SAT));
      prod_in     = PROD_W'(s1_elapsed_ff) * PROD_W'(refill_per_ms);
      if (s2_sat_ff) begin
         add_in = (refill_per_ms != '0) ? cap : '0;
      end else if (s2_prod_ff >= PROD_W'(cap)) begin
         add_in = cap;
      end else begin
         add_in = s2_prod_ff[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         started_ff  <= 1'b0;
         last_now_ff <= '0;
      end else begin
         if (s0_ready) begin
            s0_valid_ff <= req_bus.valid;
         end
         if (s1_ready) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         // every word, forward or not, leaves its time behind
         if (s0_valid_ff && s1_ready) begin
            started_ff  <= 1'b1;
            last_now_ff <= s0_now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && s0_ready) begin
         s0_seq_ff <= req_bus.sequence_req;
         s0_now_ff <= req_bus.now_ms;
      end
      if (s0_valid_ff && s1_ready) begin
         s1_seq_ff     <= s0_seq_ff;
         s1_first_ff   <= !started_ff;
         s1_refill_ff  <= started_ff && !backward_in;
         s1_sat_ff     <= sat_in;
         s1_elapsed_ff <= diff_in[LEVEL_W-1:0];
      end
      if (s1_valid_ff && s2_ready) begin
         s2_seq_ff    <= s1_seq_ff;
         s2_first_ff  <= s1_first_ff;
         s2_refill_ff <= s1_refill_ff;
         s2_sat_ff    <= s1_sat_ff;
         s2_prod_ff   <= prod_in;
      end
      if (s2_valid_ff && s3_ready) begin
         s3_word_ff.seq    <= s2_seq_ff;
         s3_word_ff.first  <= s2_first_ff;
         s3_word_ff.refill <= s2_refill_ff;
         s3_word_ff.add    <= add_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_word  = s3_word_ff;

endmodule

// File: hdl/token_bucket_sequence_admission.sv
// Token-bucket admission filter with a serial-number staleness check. Each request word
// carries a 32-bit sequence number and a 64-bit millisecond timestamp; each one gives
// exactly one response word with a verdict (admit, rate reject, stale reject) and the three
// wrapping 32-bit totals after that word. The bucket holds milli-tokens, capacity
// burst_tokens * 1000; the first word fills it, later words refill by elapsed ms times
// refill_per_ms (none if time ran backward), and an admitted or stale word spends one token.
// Throughput is one word per clock whenever the response side does not stall. The accepting
// edge loads the input register; the word then passes the elapsed-time stage, multiply stage
// and clamp stage, and the bucket and sequence update is written into the response register,
// which drives response valid. The time tracking at the input register and the bucket/sequence
// update are the only loops that close on themselves; each feeds its registered result
// straight back into its own next update, which is what allows the one-per-clock rate.
// CSR writes (index 0 refill_per_ms, 1 burst_tokens) are only to be made with the block idle.
`include "token_bucket_sequence_admission_defines.svh"

module token_bucket_sequence_admission (
   input  logic                           clock,
   input  logic                           reset,
   tbsa_req_if.sink                       req_bus,
   tbsa_rsp_if.source                     rsp_bus,
   input  logic                           csr_write_en,
   input  logic [tbsa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tbsa_pkg::CSR_W-1:0]     csr_write_data
);
   import tbsa_pkg::*;

   // config; capacity kept pre-scaled to milli-tokens
   logic [CSR_W-1:0]   refill_ff;
   logic [LEVEL_W-1:0] cap_ff;

   // admission state
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               seen_ff, seen_in;
   logic [SEQ_W-1:0]   newest_ff, newest_in;
   logic [CNT_W-1:0]   adm_cnt_ff, adm_cnt_in;
   logic [CNT_W-1:0]   rate_cnt_ff, rate_cnt_in;
   logic [CNT_W-1:0]   stale_cnt_ff, stale_cnt_in;

   // response register
   logic        rsp_valid_ff;
   verdict_type verdict_ff, verdict_in;

   // refill pipe handshake
   logic            word_valid;
   logic            word_ready;
   refill_word_type word;
   logic            fire;

   // bucket update scratch
   logic [LEVEL_W:0]   sum;
   logic [LEVEL_W-1:0] lvl;
   logic [SEQ_W-1:0]   seq_dist;
   logic               newer;

   always_ff @(posedge clock) begin
      if (reset) begin
         refill_ff <= REFILL_RESET;
         cap_ff    <= burst_to_cap(BURST_RESET);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_REFILL_PER_MS: refill_ff <= csr_write_data;
            CSR_BURST_TOKENS:  cap_ff    <= burst_to_cap(csr_write_data);
            default:           refill_ff <= refill_ff;
         endcase
      end
   end

   // elapsed time, product and clamp against capacity
   tbsa_refill u_refill (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .refill_per_ms (refill_ff),
      .cap           (cap_ff),
      .out_valid     (word_valid),
      .out_ready     (word_ready),
      .out_word      (word)
   );

   // the response register frees up the same cycle it is taken
   assign word_ready = !rsp_valid_ff || rsp_bus.ready;
   assign fire       = word_valid && word_ready;

   always_comb begin
      // refill: add is already <= cap, so the sum fits in one extra bit
      sum = {1'b0, level_ff} + {1'b0, word.add};
      if (word.first) begin
         lvl = cap_ff;
      end else if (word.refill) begin
         lvl = (sum >= {1'b0, cap_ff}) ? cap_ff : sum[LEVEL_W-1:0];
      end else begin
         lvl = level_ff;  // time ran backward: leave level alone, no clamp
      end

      // serial-number compare; half-range distance is not newer
      seq_dist = word.seq - newest_ff;
      newer    = (seq_dist != '0) && !seq_dist[SEQ_W-1];

      level_in     = lvl;
      seen_in      = seen_ff;
      newest_in    = newest_ff;
      adm_cnt_in   = adm_cnt_ff;
      rate_cnt_in  = rate_cnt_ff;
      stale_cnt_in = stale_cnt_ff;
      if (lvl < MILLI_PER_TOKEN) begin
         rate_cnt_in = rate_cnt_ff + 1'b1;
         verdict_in  = VERDICT_RATE;
      end else begin
         level_in = lvl - MILLI_PER_TOKEN;  // token spent even when stale
         if ((word.seq == '0) || (seen_ff && !newer)) begin
            stale_cnt_in = stale_cnt_ff + 1'b1;
            verdict_in   = VERDICT_STALE;
         end else begin
            seen_in    = 1'b1;
            newest_in  = word.seq;
            adm_cnt_in = adm_cnt_ff + 1'b1;
            verdict_in = VERDICT_ADMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         seen_ff      <= 1'b0;
         newest_ff    <= '0;
         adm_cnt_ff   <= '0;
         rate_cnt_ff  <= '0;
         stale_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (word_ready) begin
            rsp_valid_ff <= word_valid;
         end
         if (fire) begin
            level_ff     <= level_in;
            seen_ff      <= seen_in;
            newest_ff    <= newest_in;
            adm_cnt_ff   <= adm_cnt_in;
            rate_cnt_ff  <= rate_cnt_in;
            stale_cnt_ff <= stale_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         verdict_ff <= verdict_in;
      end
   end

   // totals shown are the counters after this word
   assign rsp_bus.valid                = rsp_valid_ff;
   assign rsp_bus.verdict              = verdict_ff;
   assign rsp_bus.admitted_total       = adm_cnt_ff;
   assign rsp_bus.rate_rejected_total  = rate_cnt_ff;
   assign rsp_bus.stale_rejected_total = stale_cnt_ff;

   // each word bumps exactly one total
   `TBSA_ASSERT_NEXT(a_one_total, clock, reset, fire,
      $countones({adm_cnt_ff != $past(adm_cnt_ff), rate_cnt_ff != $past(rate_cnt_ff),
                  stale_cnt_ff != $past(stale_cnt_ff)}) == 1)
   // only an admit moves the newest sequence
   `TBSA_ASSERT_NEXT(a_newest_on_admit, clock, reset, fire && (verdict_in != VERDICT_ADMIT),
      $stable(newest_ff) && $stable(seen_ff))
   // an admitted word becomes the newest sequence
   `TBSA_ASSERT_NEXT(a_admit_records, clock, reset, fire && (verdict_in == VERDICT_ADMIT),
      seen_ff && (newest_ff == $past(word.seq)) && (newest_ff != '0))

endmodule
